[rtl/skt_pkg.sv]
package skt_pkg;

   // fixed field widths of the request and response transfers
   localparam int CMD_W     = 2;
   localparam int KEY_IN_W  = 64;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int POS_W     = 5;
   localparam int TOTAL_W   = 6;

   // packed stream widths, padded to whole bytes
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 48;

   // parameter defaults
   localparam int DEFAULT_TABLE_DEPTH = 32;
   localparam int DEFAULT_KEY_BYTES   = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd5;

   // one command result as handed from the engine to the response register
   typedef struct packed {
      logic [TOTAL_W-1:0]  entry_total;
      logic [DATA_W-1:0]   found_data;
      logic [POS_W-1:0]    position;
      logic [STATUS_W-1:0] status;
   } skt_result_type;

endpackage

[rtl/skt_ram.sv]
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/skt_engine.sv]
module skt_engine import skt_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int KEY_BYTES   = DEFAULT_KEY_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [CMD_W-1:0]         cmd,
   input  logic [KEY_BYTES*8-1:0]   key,
   input  logic [DATA_W-1:0]        data,
   input  logic                     out_blocked,
   output logic                     busy,
   output logic                     done,
   output skt_result_type           result
);

   localparam int KEY_W   = KEY_BYTES * 8;
   localparam int ENTRY_W = KEY_W + DATA_W;
   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int CW      = $clog2(TABLE_DEPTH + 1);

   localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] ONE_CNT   = CW'(1);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_CMP   = 4'd2;
   localparam logic [3:0] S_EXEC  = 4'd3;
   localparam logic [3:0] S_UP_RD = 4'd4;
   localparam logic [3:0] S_UP_WR = 4'd5;
   localparam logic [3:0] S_PUT   = 4'd6;
   localparam logic [3:0] S_DN_RD = 4'd7;
   localparam logic [3:0] S_DN_WR = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                hit_ff, hit_in;
   logic [DATA_W-1:0]   cand_ff, cand_in;
   logic [DATA_W-1:0]   fdata_ff, fdata_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [CW-1:0]       j_dec;
   logic [CW-1:0]       j_inc;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic [KEY_W-1:0]    rd_key;
   logic [DATA_W-1:0]   rd_data;
   logic [POS_W+CW-1:0] pos_wide;
   logic [TOTAL_W+CW-1:0] total_wide;

   assign j_dec   = j_ff - ONE_CNT;
   assign j_inc   = j_ff + ONE_CNT;
   assign rd_key  = ram_rdata[ENTRY_W-1:DATA_W];
   assign rd_data = ram_rdata[DATA_W-1:0];

   // entry storage, key above payload
   skt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer: linear scan with one comparator, then shift entries one at a time, each a RAM read then a write
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      j_in      = j_ff;
      pos_in    = pos_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      data_in   = data_ff;
      hit_in    = hit_ff;
      cand_in   = cand_ff;
      fdata_in  = fdata_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_waddr = j_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = j_ff[AW-1:0];
      done      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd;
               key_in    = key;
               data_in   = data;
               j_in      = '0;
               pos_in    = '0;
               fdata_in  = '0;
               hit_in    = 1'b0;
               status_in = ST_NOT_FOUND;
               state_in  = S_RD;
            end
         end
         S_RD: begin
            if (j_ff == count_ff) begin
               hit_in   = 1'b0;
               state_in = S_EXEC;
            end else begin
               ram_re   = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_key >= key_ff) begin
               hit_in   = (rd_key == key_ff);
               cand_in  = rd_data;
               state_in = S_EXEC;
            end else begin
               j_in     = j_inc;
               state_in = S_RD;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            priority if (cmd_ff == CMD_INSERT) begin
               if (hit_ff) begin
                  status_in = ST_DUPLICATE;
               end else if (count_ff == DEPTH_CNT) begin
                  status_in = ST_FULL;
               end else begin
                  pos_in   = j_ff;
                  j_in     = count_ff;
                  state_in = S_UP_RD;
               end
            end else if (cmd_ff == CMD_SEARCH) begin
               if (hit_ff) begin
                  status_in = ST_FOUND;
                  pos_in    = j_ff;
                  fdata_in  = cand_ff;
               end
            end else if (cmd_ff == CMD_DELETE) begin
               if (hit_ff) begin
                  pos_in   = j_ff;
                  state_in = S_DN_RD;
               end
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         S_UP_RD: begin
            if (j_ff == pos_ff) begin
               state_in = S_PUT;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = j_dec[AW-1:0];
               state_in  = S_UP_WR;
            end
         end
         S_UP_WR: begin
            ram_we   = 1'b1;
            j_in     = j_dec;
            state_in = S_UP_RD;
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = {key_ff, data_ff};
            count_in  = count_ff + ONE_CNT;
            status_in = ST_INSERTED;
            state_in  = S_DONE;
         end
         S_DN_RD: begin
            if (j_inc == count_ff) begin
               count_in  = count_ff - ONE_CNT;
               status_in = ST_DELETED;
               state_in  = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = j_inc[AW-1:0];
               state_in  = S_DN_WR;
            end
         end
         S_DN_WR: begin
            ram_we   = 1'b1;
            j_in     = j_inc;
            state_in = S_DN_RD;
         end
         S_DONE: begin
            if (!out_blocked) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      pos_ff    <= pos_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      data_ff   <= data_in;
      hit_ff    <= hit_in;
      cand_ff   <= cand_in;
      fdata_ff  <= fdata_in;
      status_ff <= status_in;
   end

   // result, index and count cut or extended to the field widths
   assign pos_wide   = {{POS_W{1'b0}}, pos_ff};
   assign total_wide = {{TOTAL_W{1'b0}}, count_ff};

   assign busy               = (state_ff != S_IDLE);
   assign result.status      = status_ff;
   assign result.position    = pos_wide[POS_W-1:0];
   assign result.found_data  = fdata_ff;
   assign result.entry_total = total_wide[TOTAL_W-1:0];

   // table never holds more than its depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("entry count above table depth");

   // single port use: never read and write in the same cycle
   assert property (@(posedge clock) disable iff (reset) !(ram_we && ram_re))
      else $error("read and write in the same cycle");

   // a record is placed only when there is room
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |-> (count_ff < DEPTH_CNT))
      else $error("insert into a full table");

   // a result leaves only from the done state, which returns to idle with the entry count unchanged
   assert property (@(posedge clock) disable iff (reset)
      done |=> ((count_ff == $past(count_ff)) && (state_ff == S_IDLE)))
      else $error("count moved after result handoff");

endmodule

[rtl/sorted_key_table.sv]
// Sorted key table: holds up to TABLE_DEPTH records (a KEY_BYTES-byte key and a
// 32-bit payload) in ascending unsigned key order in a simple dual-port RAM, and
// runs one insert, search or delete command per request transfer, returning
// one response transfer each. A command first scans the table from index 0
// with one comparator, one entry examined at a time, until it reaches a key
// not below the request key or the end of the table; an insert then moves
// each larger entry up and a delete moves each entry above the match down,
// one entry at a time, since every move is a RAM read followed by a write,
// and req_tready is low while the command runs. The finished result sits
// in an output register, so the next request is taken while it waits for
// rsp_tready. Key bits above KEY_BYTES*8 are ignored; command code 3
// reports not found and changes nothing.
module sorted_key_table import skt_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int KEY_BYTES   = DEFAULT_KEY_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // command [1:0], key [65:2], record_data [97:66], zero [103:98]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status [2:0], position [7:3], found_data [39:8], entry_total [45:40], zero [47:46]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int KEY_W = KEY_BYTES * 8;

   logic               busy;
   logic               done;
   logic               start;
   logic               out_blocked;
   skt_result_type     result;
   logic               rsp_valid_ff, rsp_valid_in;
   skt_result_type     rsp_ff, rsp_in;
   logic [CMD_W-1:0]   req_cmd;
   logic [KEY_IN_W-1:0] req_key;
   logic [DATA_W-1:0]  req_data;

   // request field unpacking
   assign req_cmd  = req_tdata[CMD_W-1:0];
   assign req_key  = req_tdata[CMD_W+KEY_IN_W-1:CMD_W];
   assign req_data = req_tdata[CMD_W+KEY_IN_W+DATA_W-1:CMD_W+KEY_IN_W];

   assign req_tready  = !busy;
   assign start       = req_tvalid && !busy;
   assign out_blocked = rsp_valid_ff && !rsp_tready;

   skt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (req_cmd),
      .key         (req_key[KEY_W-1:0]),
      .data        (req_data),
      .out_blocked (out_blocked),
      .busy        (busy),
      .done        (done),
      .result      (result)
   );

   // response register: load on handoff, clear after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(skt_result_type)){1'b0}}, rsp_ff};

endmodule
